// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASRT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASRT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/lbfg_pkg.sv =====
`timescale 1ns / 1ps

package lbfg_pkg;

	localparam logic [7:0]  UP_DEF        = 8'd70;
	localparam logic [7:0]  DIFF_DEF      = 8'd20;
	localparam logic [7:0]  PERCENT       = 8'd100;
	localparam logic [15:0] MAX_FREQ_RST  = 16'hFFFF;
	localparam int          BIG_BIT       = 24;
	localparam int          BIG_SHIFT     = 7;
	localparam logic [19:0] MEGA          = 20'd1000000;
	localparam logic [13:0] MEGA_DIV64    = 14'd15625;
	localparam logic [2:0]  DROPS_NEEDED  = 3'd4;
	localparam logic [15:0] RESET_TARGET  = 16'd800;

	localparam logic [1:0]  REG_UP        = 2'd0;
	localparam logic [1:0]  REG_DIFF      = 2'd1;
	localparam logic [1:0]  REG_MAX       = 2'd2;

endpackage

// ===== rtl/load_based_frequency_governor.sv =====
`timescale 1ns / 1ps
// Load based frequency governor.
// Input channel (in_valid/in_ready): one load sample per transaction, with busy_ticks,
// total_ticks and cur_freq. Output channel (out_valid/out_ready): one
// target_frequency and status per sample, in order.
// Configuration goes through the APB port: up_threshold at 0x0, down_differential
// at 0x4, max_frequency at 0x8; pready is always high, reads return the registers.
// in_ready is high only while the sequencer is idle. Invalid settings and zero total
// pass through PREP then DONE, loads above the threshold through PREP, UP and DONE,
// loads inside the band through PREP, UP, BAND and DONE. A computed target also
// passes MUL1, MUL2, DIV1, MUL3, DIV2 and FILT: two 64-step passes of the shared
// restoring divider (load ratio, then percent scaling) dominate. in_ready rises
// with out_valid, so a new sample is accepted only once the last result is loaded.
// The result sits in an output register, so the next sample is accepted while it
// waits; if a second result is ready before the first is taken, the sequencer
// holds it and stays not ready until out_ready frees the register.
// Reset restores the register defaults (70, 20, 65535), sets the last computed
// target to 800, clears the drop counter and empties the output register.
`include "assert_macros.svh"

module load_based_frequency_governor import lbfg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] busy_ticks,
	input  logic [31:0] total_ticks,
	input  logic [15:0] cur_freq,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] target_frequency,
	output logic        status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_UP,
		ST_BAND,
		ST_MUL1,
		ST_MUL2,
		ST_DIV1,
		ST_MUL3,
		ST_DIV2,
		ST_FILT,
		ST_DONE
	} state_t;

	state_t      state_q;
	logic [7:0]  up_q;
	logic [7:0]  diff_q;
	logic [15:0] max_q;
	logic [15:0] last_q;
	logic [2:0]  drop_cnt_q;
	logic        out_valid_q;
	logic [15:0] out_freq_q;
	logic        out_stat_q;
	logic [15:0] res_freq_q;
	logic        res_stat_q;

	logic [31:0] busy_q;
	logic [31:0] total_q;
	logic [15:0] cur_q;
	logic [40:0] prod_q;
	logic [63:0] dvd_q;
	logic [26:0] dvsr_q;
	logic [26:0] rem_q;
	logic [5:0]  cnt_q;

	logic        cfg_wr;
	logic [7:0]  up_eff;
	logic [7:0]  diff_eff;
	logic [7:0]  band;
	logic [7:0]  divs;
	logic        bad_cfg;
	logic        big_time;
	logic [32:0] busy_pct;
	logic [32:0] total_up;
	logic [32:0] total_band;
	logic [54:0] scaled;
	logic [42:0] pct_q1;
	logic [27:0] rem_shift;
	logic        qbit;
	logic [26:0] rem_next;
	logic [15:0] freq;
	logic [2:0]  cnt_inc;
	logic        out_free;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_UP:   prdata = {24'd0, up_q};
			REG_DIFF: prdata = {24'd0, diff_q};
			REG_MAX:  prdata = {16'd0, max_q};
			default:  prdata = 32'd0;
		endcase
	end

	assign up_eff   = (up_q == 8'd0) ? UP_DEF : up_q;
	assign diff_eff = (diff_q == 8'd0) ? DIFF_DEF : diff_q;
	assign bad_cfg  = (up_eff > PERCENT) || (up_eff < diff_eff);
	assign band     = up_eff - diff_eff;
	assign divs     = ((up_eff - {1'b0, diff_eff[7:1]}) == 8'd0) ? 8'd1
	                : (up_eff - {1'b0, diff_eff[7:1]});
	assign big_time = (|busy_q[31:BIG_BIT]) || (|total_q[31:BIG_BIT]);

	assign busy_pct   = 33'(busy_q[24:0]) * 33'(PERCENT);
	assign total_up   = 33'(total_q[24:0]) * 33'(up_eff);
	assign total_band = 33'(total_q[24:0]) * 33'(band);
	assign scaled     = 55'(prod_q) * 55'(MEGA_DIV64);
	assign pct_q1     = 43'(dvd_q[35:0]) * 43'(PERCENT);

	// shared restoring divider step
	assign rem_shift = {rem_q, dvd_q[63]};
	assign qbit      = rem_shift >= {1'b0, dvsr_q};
	assign rem_next  = qbit ? 27'(rem_shift - {1'b0, dvsr_q}) : rem_shift[26:0];

	assign freq     = (|dvd_q[63:16]) ? 16'hFFFF : dvd_q[15:0];
	assign cnt_inc  = drop_cnt_q + 3'd1;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			up_q        <= UP_DEF;
			diff_q      <= DIFF_DEF;
			max_q       <= MAX_FREQ_RST;
			last_q      <= RESET_TARGET;
			drop_cnt_q  <= 3'd0;
			out_valid_q <= 1'b0;
			out_freq_q  <= 16'd0;
			out_stat_q  <= 1'b0;
			res_freq_q  <= 16'd0;
			res_stat_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_UP:   up_q   <= pwdata[7:0];
					REG_DIFF: diff_q <= pwdata[7:0];
					REG_MAX:  max_q  <= pwdata[15:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					res_stat_q <= bad_cfg;
					if (bad_cfg) begin
						res_freq_q <= 16'd0;
						state_q    <= ST_DONE;
					end else if (total_q == 32'd0) begin
						res_freq_q <= max_q;
						state_q    <= ST_DONE;
					end else begin
						state_q <= ST_UP;
					end
				end
				ST_UP: begin
					if (busy_pct > total_up || cur_q == 16'd0) begin
						res_freq_q <= max_q;
						state_q    <= ST_DONE;
					end else begin
						state_q <= ST_BAND;
					end
				end
				ST_BAND: begin
					if (busy_pct > total_band) begin
						res_freq_q <= cur_q;
						state_q    <= ST_DONE;
					end else begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_DIV1;
				ST_DIV1: begin
					if (cnt_q == 6'd0) begin
						state_q <= ST_MUL3;
					end
				end
				ST_MUL3: state_q <= ST_DIV2;
				ST_DIV2: begin
					if (cnt_q == 6'd0) begin
						state_q <= ST_FILT;
					end
				end
				ST_FILT: begin
					if (freq < last_q && cnt_inc < DROPS_NEEDED) begin
						drop_cnt_q <= cnt_inc;
						res_freq_q <= cur_q;
					end else begin
						drop_cnt_q <= 3'd0;
						res_freq_q <= freq;
					end
					last_q  <= freq;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_freq_q  <= res_freq_q;
						out_stat_q  <= res_stat_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				busy_q  <= busy_ticks;
				total_q <= total_ticks;
				cur_q   <= cur_freq;
			end
			ST_PREP: begin
				if (big_time) begin
					busy_q  <= busy_q >> BIG_SHIFT;
					total_q <= total_q >> BIG_SHIFT;
				end
			end
			ST_MUL1: begin
				prod_q <= 41'(busy_q[24:0]) * 41'(cur_q);
			end
			ST_MUL2: begin
				dvd_q  <= {3'd0, scaled, 6'd0};
				dvsr_q <= {2'd0, total_q[24:0]};
				rem_q  <= 27'd0;
				cnt_q  <= 6'd63;
			end
			ST_MUL3: begin
				dvd_q  <= {21'd0, pct_q1};
				dvsr_q <= 27'(divs) * 27'(MEGA);
				rem_q  <= 27'd0;
				cnt_q  <= 6'd63;
			end
			ST_DIV1, ST_DIV2: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[62:0], qbit};
				cnt_q <= cnt_q - 6'd1;
			end
			default: ;
		endcase
	end

	assign in_ready         = (state_q == ST_IDLE);
	assign out_valid        = out_valid_q;
	assign target_frequency = out_freq_q;
	assign status           = out_stat_q;

	`ASRT_IMP(a_drop_cnt_range, 1'b1, drop_cnt_q < DROPS_NEEDED)
	`ASRT_IMP(a_rem_below_dvsr, (state_q == ST_DIV1) || (state_q == ST_DIV2), rem_q < dvsr_q)
	`ASRT_IMP(a_bad_cfg_zero, out_valid_q && out_stat_q, out_freq_q == 16'd0)
	`ASRT_NXT(a_accept_busy, in_valid && in_ready, state_q == ST_PREP)

endmodule

// ===== dv/tb_load_based_frequency_governor.sv =====
`timescale 1ns / 1ps

module tb_load_based_frequency_governor import lbfg_pkg::*;;

	typedef struct {
		logic [31:0] busy;
		logic [31:0] total;
		logic [15:0] cur;
	} load_sample_t;

	typedef struct packed {
		logic [15:0] freq;
		logic        st;
	} governor_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] busy_ticks = '0;
	logic [31:0] total_ticks = '0;
	logic [15:0] cur_freq = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] target_frequency;
	logic        status;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	load_sample_t     sample_q[$];
	governor_result_t target_q[$];
	int               mismatches = 0;

	// governor model state
	logic [7:0]  cfg_up = UP_DEF;
	logic [7:0]  cfg_diff = DIFF_DEF;
	logic [15:0] cfg_max = MAX_FREQ_RST;
	logic [15:0] last_target = RESET_TARGET;
	logic [2:0]  drop_cnt = '0;

	load_based_frequency_governor u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.busy_ticks(busy_ticks),
		.total_ticks(total_ticks),
		.cur_freq(cur_freq),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.target_frequency(target_frequency),
		.status(status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic governor_result_t predict_target(input logic [31:0] busy_in,
			input logic [31:0] total_in, input logic [15:0] cur_in);
		logic [63:0]      busy;
		logic [63:0]      total;
		logic [63:0]      cur;
		logic [63:0]      up;
		logic [63:0]      diff;
		logic [63:0]      ratio;
		logic [63:0]      divisor;
		logic [15:0]      freq;
		governor_result_t r;
		busy = 64'(busy_in);
		total = 64'(total_in);
		cur = 64'(cur_in);
		up = 64'((cfg_up == 8'd0) ? UP_DEF : cfg_up);
		diff = 64'((cfg_diff == 8'd0) ? DIFF_DEF : cfg_diff);
		r.st = 1'b0;
		r.freq = cfg_max;
		if (up > 64'(PERCENT) || up < diff) begin
			r.freq = '0;
			r.st = 1'b1;
			return r;
		end
		if (total == 0)
			return r;
		if (busy >= (64'd1 << BIG_BIT) || total >= (64'd1 << BIG_BIT)) begin
			busy = busy >> BIG_SHIFT;
			total = total >> BIG_SHIFT;
		end
		if (busy * 64'(PERCENT) > total * up)
			return r;
		if (cur == 0)
			return r;
		if (busy * 64'(PERCENT) > total * (up - diff)) begin
			r.freq = cur_in;
			return r;
		end
		if (total == 0)
			return r;
		ratio = busy * (cur * 64'(MEGA)) / total;
		divisor = up - diff / 2;
		if (divisor == 0)
			divisor = 1;
		ratio = ratio * 64'(PERCENT) / divisor / 64'(MEGA);
		freq = (ratio > 64'hFFFF) ? 16'hFFFF : ratio[15:0];
		if (freq < last_target) begin
			last_target = freq;
			drop_cnt = drop_cnt + 3'd1;
			if (drop_cnt < DROPS_NEEDED) begin
				r.freq = cur_in;
				return r;
			end
		end
		drop_cnt = '0;
		last_target = freq;
		r.freq = freq;
		return r;
	endfunction

	// mostly back-to-back or short gaps, a few long ones, and calm stretches
	function automatic int pick_gap(inout int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(8, 60);
	endfunction

	// sample driver
	always @(posedge clk) begin : drv
		load_sample_t s;
		int           in_gap;
		int           in_calm;
		if (arst_n) begin
			if (in_valid && in_ready)
				target_q.push_back(predict_target(busy_ticks, total_ticks, cur_freq));
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					s = sample_q.pop_front();
					busy_ticks <= s.busy;
					total_ticks <= s.total;
					cur_freq <= s.cur;
					in_valid <= 1'b1;
					in_gap = pick_gap(in_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : mon
		governor_result_t exp_r;
		int               out_stall;
		int               out_calm;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (target_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected transaction: target %0d status %0d",
							target_frequency, status);
					mismatches++;
				end else begin
					exp_r = target_q.pop_front();
					if (target_frequency !== exp_r.freq || status !== exp_r.st) begin
						if (mismatches < 10)
							$display("mismatch: target exp %0d got %0d, status exp %0d got %0d",
								exp_r.freq, target_frequency, exp_r.st, status);
						mismatches++;
					end
				end
				out_stall = pick_gap(out_calm);
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_governor(input logic [7:0] up, input logic [7:0] diff,
			input logic [15:0] fmax);
		apb_write(REG_UP, ({$urandom()} & 32'hFFFF_FF00) | 32'(up));
		apb_write(REG_DIFF, ({$urandom()} & 32'hFFFF_FF00) | 32'(diff));
		apb_write(REG_MAX, ({$urandom()} & 32'hFFFF_0000) | 32'(fmax));
		cfg_up = up;
		cfg_diff = diff;
		cfg_max = fmax;
	endtask

	task automatic push_sample(input logic [31:0] busy, input logic [31:0] total,
			input logic [15:0] cur);
		load_sample_t s;
		s.busy = busy;
		s.total = total;
		s.cur = cur;
		sample_q.push_back(s);
	endtask

	task automatic push_random_samples(input int count);
		int          n;
		int          kind;
		int          up_e;
		int          diff_e;
		int          band_lo;
		int          pct;
		int          k;
		logic [63:0] tot;
		logic [15:0] cur;
		n = 0;
		up_e = (cfg_up == 0) ? UP_DEF : cfg_up;
		diff_e = (cfg_diff == 0) ? DIFF_DEF : cfg_diff;
		band_lo = (up_e > diff_e) ? up_e - diff_e : 0;
		if (band_lo > 100)
			band_lo = 100;
		while (n < count) begin
			kind = $urandom_range(0, 99);
			tot = {$urandom()} >> $urandom_range(0, 31);
			if (tot == 0)
				tot = 1;
			cur = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 2000))
				: 16'($urandom_range(1, 65535));
			if (kind < 45) begin
				pct = $urandom_range(0, band_lo);
				push_sample(32'(tot * pct / 100), tot[31:0], cur);
				n++;
			end else if (kind < 65) begin
				// falling load on one operating point
				pct = band_lo;
				for (k = 0; k < 5; k++) begin
					push_sample(32'(tot * pct / 100), tot[31:0], cur);
					pct = pct - $urandom_range(0, pct / 4 + 1);
					if (pct < 0)
						pct = 0;
				end
				n += 5;
			end else if (kind < 75) begin
				pct = $urandom_range(band_lo, (up_e > 100) ? 100 : up_e);
				push_sample(32'(tot * pct / 100), tot[31:0], cur);
				n++;
			end else if (kind < 85) begin
				push_sample($urandom(), $urandom(), 16'($urandom()));
				n++;
			end else if (kind < 90) begin
				push_sample($urandom() >> $urandom_range(0, 31), '0, cur);
				n++;
			end else if (kind < 95) begin
				pct = $urandom_range(0, band_lo);
				push_sample(32'(tot * pct / 100), tot[31:0], '0);
				n++;
			end else begin
				tot = {$urandom()} | 32'h0100_0000;
				pct = $urandom_range(0, 100);
				push_sample(32'(tot * pct / 100), tot[31:0], cur);
				n++;
			end
		end
	endtask

	task automatic wait_drained();
		while (sample_q.size() > 0 || in_valid || target_q.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int          p;
		logic [7:0]  up_v;
		logic [7:0]  diff_v;
		logic [15:0] max_v;
		int          n_items;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed samples at reset settings
		push_sample(32'd0, 32'd0, 16'd1000);
		push_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		push_sample(32'd40, 32'd100, 16'd1000);
		push_sample(32'd30, 32'd100, 16'd1000);
		push_sample(32'd20, 32'd100, 16'd1000);
		push_sample(32'd10, 32'd100, 16'd1000);
		push_sample(32'd45, 32'd100, 16'd1000);
		push_sample(32'd10, 32'd100, 16'd0);
		push_sample(32'd60, 32'd100, 16'd1234);
		push_sample(32'd70, 32'd100, 16'd4321);
		push_sample(32'd71, 32'd100, 16'd4321);
		push_sample(32'd200, 32'd100, 16'd500);
		push_sample(32'd0, 32'h0100_0000, 16'd777);
		push_sample(32'h0100_0000, 32'd100, 16'd777);
		push_sample(32'hFFFF_FFFF, 32'd1, 16'd1);
		push_sample(32'h00FF_FFFF, 32'h00FF_FFFF, 16'd100);
		push_sample(32'd40, 32'd100, 16'hFFFF);
		push_sample(32'h0050_0000, 32'h0100_0000, 16'hFFFF);
		push_sample(32'd1, 32'hFFFF_FFFF, 16'hFFFF);
		push_sample(32'd50, 32'd100, 16'hFFFF);
		wait_drained();

		for (p = 0; p < 14; p++) begin
			n_items = 70;
			case (p)
				0: begin up_v = 8'd0; diff_v = 8'd0; max_v = 16'($urandom()); end
				1: begin up_v = 8'd100; diff_v = 8'd100; max_v = 16'hFFFF; end
				2: begin up_v = 8'd1; diff_v = 8'd1; max_v = 16'd0; end
				3: begin up_v = 8'd100; diff_v = 8'd1; max_v = 16'($urandom()); end
				4: begin up_v = 8'd255; diff_v = 8'd20; max_v = 16'd1000; n_items = 20; end
				5: begin up_v = 8'd30; diff_v = 8'd50; max_v = 16'd1000; n_items = 20; end
				default: begin
					if ($urandom_range(0, 4) == 0) begin
						up_v = 8'($urandom());
						diff_v = 8'($urandom());
					end else begin
						up_v = 8'($urandom_range(1, 100));
						diff_v = 8'($urandom_range(1, up_v));
					end
					max_v = 16'($urandom());
				end
			endcase
			set_governor(up_v, diff_v, max_v);
			push_random_samples(n_items);
			wait_drained();
		end

		repeat (300) @(posedge clk);
		if (mismatches == 0 && target_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
